>>> hdl/h264aus_pkg.sv
`default_nettype none

package h264aus_pkg;

    // One byte of the elementary stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in_item;

    // One access unit descriptor
    typedef struct packed {
        logic [23:0] frame_bytes;
        logic        is_idr;
        logic [31:0] timestamp;
        logic        size_clipped;
        logic        last_of_run;
    } t_out_item;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SEARCH     = 3'd0,
        PH_HEADER     = 3'd1,
        PH_BODY       = 3'd2,
        PH_NEXT_HDR   = 3'd3,
        PH_NEXT_FIRST = 3'd4
    } t_phase;

    // Register map (index = byte address / 4)
    localparam logic REG_FRAME_PERIOD = 1'b0;

    localparam logic [15:0] FRAME_PERIOD_RST = 16'd40;

    // NAL header fields
    localparam logic [4:0] NAL_TYPE_SLICE_MIN = 5'd1;
    localparam logic [4:0] NAL_TYPE_IDR       = 5'd5;
    localparam logic [7:0] START_CODE_LAST    = 8'h01;

    // Result queue
    localparam int OUT_DEPTH = 4;
    localparam int PTR_BITS  = 2;
    localparam int CNT_W     = 3;

    // Types 1..5 are coded slices
    function automatic logic nal_is_slice(input logic [7:0] hdr);
        logic [4:0] t;
        begin
            t = hdr[4:0];
            return (t >= NAL_TYPE_SLICE_MIN) && (t <= NAL_TYPE_IDR);
        end
    endfunction

    function automatic logic nal_is_idr(input logic [7:0] hdr);
        return hdr[4:0] == NAL_TYPE_IDR;
    endfunction

endpackage

`default_nettype wire

>>> hdl/h264_access_unit_splitter.sv
`default_nettype none

// Channel   Direction  Handshake                      Payload
// in        input      i_in_valid / o_in_ready        i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_ready      o_out_data (t_out_item)
// cfg       input      psel / penable / pwrite        paddr, pwdata, prdata
//
// One byte is taken per cycle while o_in_ready is high; its zero, one or two descriptors are written
// into a four-entry result queue at the same clock edge.
// Input is ready while the queue has room for two descriptors, so a stalled
// consumer holds off the byte stream once three or more descriptors are waiting.
// A descriptor reaches the output from the registered queue, not combinationally from its byte.
// Reset clears the parser, the queue and the timestamp; frame_period
// returns to 40.
module h264_access_unit_splitter #(
    parameter int COUNT_BITS = 24
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // byte stream
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  h264aus_pkg::t_in_item        i_in_data,
    // access unit descriptors
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output h264aus_pkg::t_out_item       o_out_data,
    // register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [2:0]                   paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import h264aus_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ZERO  = '0;
    localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] SC_SHORT  = COUNT_BITS'(3);
    localparam logic [COUNT_BITS-1:0] SC_LONG   = COUNT_BITS'(4);

    function automatic logic [COUNT_BITS-1:0] sat_add(
        input logic [COUNT_BITS-1:0] a,
        input logic [COUNT_BITS-1:0] n
    );
        logic [COUNT_BITS:0] s;
        begin
            s = {1'b0, a} + {1'b0, n};
            if (s >= {1'b0, CNT_MAX}) return CNT_MAX;
            return s[COUNT_BITS-1:0];
        end
    endfunction

    function automatic t_out_item make_result(
        input logic [COUNT_BITS-1:0] bytes,
        input logic                  idr,
        input logic [31:0]           ts,
        input logic                  last
    );
        logic [31:0] wide;
        t_out_item   r;
        begin
            wide           = 32'(bytes);
            r.frame_bytes  = wide[23:0];
            r.is_idr       = idr;
            r.timestamp    = ts;
            r.size_clipped = (bytes == CNT_MAX);
            r.last_of_run  = last;
            return r;
        end
    endfunction

    // Parser state
    logic [23:0]           r_window,   n_window;
    t_phase                r_phase,    n_phase;
    logic                  r_cur_slice, n_cur_slice;
    logic                  r_cur_idr,  n_cur_idr;
    logic [COUNT_BITS-1:0] r_frame,    n_frame;
    logic [COUNT_BITS-1:0] r_pending,  n_pending;
    logic [31:0]           r_ts,       n_ts;
    logic [15:0]           r_period;

    // Result queue
    t_out_item             r_mem [OUT_DEPTH];
    logic [PTR_BITS-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]      r_count;

    // Emission slots
    logic                  step_emit;
    logic                  fin_emit0, fin_emit1;
    logic [COUNT_BITS-1:0] fin_bytes0, fin_bytes1;
    logic                  fin_idr0, fin_idr1;
    t_out_item             slot0, slot1;
    logic [1:0]            push_cnt;

    logic                  in_fire, out_fire, cfg_wr;
    logic [7:0]            b, inv;
    logic [23:0]           shifted;
    logic                  sc;
    logic [COUNT_BITS-1:0] sc_len;
    logic [31:0]           ts_p1, ts_p2;

    assign in_fire  = i_in_valid & o_in_ready;
    assign out_fire = o_out_valid & i_out_ready;
    assign b        = i_in_data.data_byte;
    assign inv      = ~b;
    assign shifted  = {r_window[15:0], inv};
    assign sc       = (r_window[15:0] == 16'hFFFF) && (b == START_CODE_LAST);
    assign sc_len   = (r_window[23:16] == 8'hFF) ? SC_LONG : SC_SHORT;

    // Parser next state for the byte in flight
    always_comb begin
        logic [COUNT_BITS-1:0] pend_inc;
        logic [COUNT_BITS-1:0] grp;
        logic [7:0]            hdr;
        logic [7:0]            hdr_next;
        n_window    = r_window;
        n_phase     = r_phase;
        n_cur_slice = r_cur_slice;
        n_cur_idr   = r_cur_idr;
        n_frame     = r_frame;
        n_pending   = r_pending;
        step_emit   = 1'b0;
        fin_emit0   = 1'b0;
        fin_emit1   = 1'b0;
        fin_bytes0  = r_frame;
        fin_bytes1  = r_pending;
        fin_idr0    = r_cur_idr;
        fin_idr1    = 1'b0;
        pend_inc    = sat_add(r_pending, CNT_ONE);
        grp         = pend_inc;
        hdr         = ~r_window[7:0];
        hdr_next    = 8'h00;
        if (in_fire) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    n_window = shifted;
                    if (sc) begin
                        n_frame = sat_add(CNT_ZERO, sc_len);
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    n_frame     = sat_add(r_frame, CNT_ONE);
                    n_cur_slice = nal_is_slice(b);
                    n_cur_idr   = nal_is_idr(b);
                    n_window    = '0;
                    n_phase     = PH_BODY;
                end
                PH_BODY: begin
                    n_window = shifted;
                    if (!sc) begin
                        n_frame = sat_add(r_frame, CNT_ONE);
                    end else if (!r_cur_slice) begin
                        n_frame = sat_add(r_frame, CNT_ONE);
                        n_phase = PH_HEADER;
                    end else begin
                        // pull the start code bytes already counted back out
                        if (r_frame != CNT_MAX) begin
                            n_frame = (r_frame >= sc_len - CNT_ONE)
                                    ? r_frame - (sc_len - CNT_ONE) : CNT_ZERO;
                        end
                        n_pending = sc_len;
                        n_phase   = PH_NEXT_HDR;
                    end
                end
                PH_NEXT_HDR: begin
                    n_pending = pend_inc;
                    if (nal_is_slice(b)) begin
                        n_window = {16'h0000, inv};
                        n_phase  = PH_NEXT_FIRST;
                    end else begin
                        // non-slice NAL closes the frame
                        step_emit   = 1'b1;
                        n_frame     = pend_inc;
                        n_pending   = '0;
                        n_cur_slice = 1'b0;
                        n_cur_idr   = 1'b0;
                        n_window    = '0;
                        n_phase     = PH_BODY;
                    end
                end
                PH_NEXT_FIRST: begin
                    if (b[7]) begin
                        // first_mb_in_slice is zero: a new picture starts
                        step_emit = 1'b1;
                        n_frame   = grp;
                    end else begin
                        n_frame   = sat_add(r_frame, grp);
                    end
                    n_pending   = '0;
                    n_cur_slice = 1'b1;
                    n_cur_idr   = nal_is_idr(hdr);
                    n_window    = {16'h0000, inv};
                    n_phase     = PH_BODY;
                end
                default: begin
                    n_window    = '0;
                    n_phase     = PH_SEARCH;
                    n_cur_slice = 1'b0;
                    n_cur_idr   = 1'b0;
                    n_frame     = '0;
                    n_pending   = '0;
                end
            endcase

            // flush at end of stream
            if (i_in_data.stream_end) begin
                hdr_next   = ~n_window[7:0];
                fin_bytes0 = n_frame;
                fin_idr0   = n_cur_idr;
                fin_bytes1 = n_pending;
                fin_idr1   = nal_is_idr(hdr_next);
                if (n_phase == PH_NEXT_HDR) begin
                    fin_emit0 = 1'b1;
                end else if (n_phase == PH_NEXT_FIRST) begin
                    fin_emit0 = 1'b1;
                    fin_emit1 = 1'b1;
                end else if (n_phase == PH_BODY && n_cur_slice) begin
                    fin_emit0 = 1'b1;
                end
                n_window    = '0;
                n_phase     = PH_SEARCH;
                n_cur_slice = 1'b0;
                n_cur_idr   = 1'b0;
                n_frame     = '0;
                n_pending   = '0;
            end
        end
    end

    // Pack descriptors and advance the timestamp
    assign ts_p1 = r_ts + 32'(r_period);
    assign ts_p2 = ts_p1 + 32'(r_period);

    always_comb begin
        push_cnt = 2'(step_emit) + 2'(fin_emit0) + 2'(fin_emit1);
        if (step_emit) begin
            slot0 = make_result(r_frame, r_cur_idr, r_ts, !fin_emit0);
            slot1 = make_result(fin_bytes0, fin_idr0, ts_p1, 1'b1);
        end else begin
            slot0 = make_result(fin_bytes0, fin_idr0, r_ts, !fin_emit1);
            slot1 = make_result(fin_bytes1, fin_idr1, ts_p1, 1'b1);
        end
        unique case (push_cnt)
            2'd0:    n_ts = r_ts;
            2'd1:    n_ts = ts_p1;
            default: n_ts = ts_p2;
        endcase
    end

    // Parser and timestamp registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_phase     <= PH_SEARCH;
            r_cur_slice <= 1'b0;
            r_cur_idr   <= 1'b0;
            r_frame     <= '0;
            r_pending   <= '0;
            r_ts        <= '0;
        end else begin
            r_window    <= n_window;
            r_phase     <= n_phase;
            r_cur_slice <= n_cur_slice;
            r_cur_idr   <= n_cur_idr;
            r_frame     <= n_frame;
            r_pending   <= n_pending;
            r_ts        <= n_ts;
        end
    end

    // Register port
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAME_PERIOD) ? {16'h0000, r_period} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= FRAME_PERIOD_RST;
        end else if (cfg_wr && paddr[2] == REG_FRAME_PERIOD) begin
            r_period <= pwdata[15:0];
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr] <= slot0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[r_wr + PTR_BITS'(1)] <= slot1;
        end
    end

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_BITS'(push_cnt);
            r_rd    <= r_rd + PTR_BITS'(out_fire);
            r_count <= r_count + CNT_W'(push_cnt) - CNT_W'(out_fire);
        end
    end

    assign o_in_ready  = (r_count <= CNT_W'(OUT_DEPTH - 2));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rd];

    // Checks
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(OUT_DEPTH))
        else $error("result queue overfilled");

    a_pending_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != '0) == (r_phase == PH_NEXT_HDR || r_phase == PH_NEXT_FIRST))
        else $error("pending count out of step with phase");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_data.stream_end) |=>
            (r_phase == PH_SEARCH && r_frame == '0 && r_window == '0))
        else $error("parser not cleared after end of stream");

endmodule

`default_nettype wire

>>> tb/sv/h264_access_unit_splitter_tb.sv
`timescale 1ns / 1ps

module h264_access_unit_splitter_tb;

    import h264aus_pkg::*;

    localparam int          CYCLE_LIMIT    = 500000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          RX_HOLD_CYCLES = 600;
    localparam int          PHASE_BYTES    = 340;
    localparam int          NUM_PHASES     = 5;
    localparam int          MAX_GAP        = 17;
    localparam int          MAX_REPORTS    = 10;
    localparam logic [23:0] COUNT_MAX      = 24'hFF_FFFF;
    localparam logic [15:0] PERIOD_MIN     = 16'h0000;
    localparam logic [15:0] PERIOD_MAX     = 16'hFFFF;
    localparam logic [15:0] PERIOD_ONE     = 16'h0001;

    // Register addresses, one 32-bit word per register
    localparam logic [2:0] ADDR_FRAME_PERIOD = {REG_FRAME_PERIOD, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED     = {~REG_FRAME_PERIOD, 2'b00};

    // NAL unit types used by the stream generator
    localparam logic [4:0] NAL_UNSPEC   = 5'd0;
    localparam logic [4:0] NAL_NON_IDR  = 5'd1;
    localparam logic [4:0] NAL_PART_C   = 5'd4;
    localparam logic [4:0] NAL_SEI      = 5'd6;
    localparam logic [4:0] NAL_SPS      = 5'd7;
    localparam logic [4:0] NAL_PPS      = 5'd8;
    localparam logic [4:0] NAL_TYPE_TOP = 5'd31;

    // Clock, reset and block ports
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    t_in_item    in_data    = '0;
    logic        out_ready  = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic [31:0] prdata;
    logic        pready;

    // Stimulus and scoreboard
    t_in_item    byte_q[$];
    logic [7:0]  stream_buf[$];
    t_out_item   pending_aus[$];
    t_out_item   step_aus[$];
    int          bytes_queued = 0;
    int          bytes_taken  = 0;
    int          err_cnt      = 0;
    int unsigned cycle_cnt    = 0;
    logic        idle_on      = 1'b1;
    logic        rx_hold_req  = 1'b0;
    logic        rx_hold_done = 1'b0;
    int          rx_hold_left = 0;
    int          rx_wait      = 0;
    int          tx_gap       = 0;

    // Splitter state as the scoreboard tracks it
    logic [23:0] win;
    t_phase      ph;
    logic        cur_slice;
    logic        cur_idr;
    logic [23:0] au_cnt;
    logic [23:0] pend_cnt;
    logic [31:0] ts_now;
    logic [15:0] period;

    h264_access_unit_splitter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        if (!idle_on || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [23:0] add_sat(input logic [23:0] a, input logic [23:0] n);
        logic [24:0] sum;
        sum = {1'b0, a} + {1'b0, n};
        return (sum >= {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[23:0];
    endfunction

    function automatic logic is_slice_hdr(input logic [7:0] hdr);
        return (hdr[4:0] >= NAL_TYPE_SLICE_MIN) && (hdr[4:0] <= NAL_TYPE_IDR);
    endfunction

    task automatic clear_parser();
        win       = '0;
        ph        = PH_SEARCH;
        cur_slice = 1'b0;
        cur_idr   = 1'b0;
        au_cnt    = '0;
        pend_cnt  = '0;
    endtask

    // Emit one access unit descriptor and advance the timestamp
    task automatic close_au(input logic [23:0] n, input logic idr);
        t_out_item au;
        au.frame_bytes  = n;
        au.is_idr       = idr;
        au.timestamp    = ts_now;
        au.size_clipped = (n == COUNT_MAX);
        au.last_of_run  = 1'b0;
        step_aus.push_back(au);
        ts_now = ts_now + {16'h0, period};
    endtask

    // Advance the splitter state by one byte and queue the descriptors it closes
    task automatic parse_byte(input t_in_item it);
        logic [7:0]  b;
        logic [7:0]  hdr;
        logic        sc;
        logic [23:0] sc_len;
        logic [23:0] grp;
        t_out_item   tail;
        b = it.data_byte;
        step_aus.delete();
        sc     = (win[15:0] == 16'hFFFF) && (b == START_CODE_LAST);
        sc_len = (win[23:16] == 8'hFF) ? 24'd4 : 24'd3;
        case (ph)
            PH_SEARCH: begin
                win = {win[15:0], ~b};
                if (sc) begin
                    au_cnt = add_sat('0, sc_len);
                    ph     = PH_HEADER;
                end
            end
            PH_HEADER: begin
                au_cnt    = add_sat(au_cnt, 24'd1);
                cur_slice = is_slice_hdr(b);
                cur_idr   = (b[4:0] == NAL_TYPE_IDR);
                win       = '0;
                ph        = PH_BODY;
            end
            PH_BODY: begin
                win = {win[15:0], ~b};
                if (!sc) begin
                    au_cnt = add_sat(au_cnt, 24'd1);
                end else if (!cur_slice) begin
                    au_cnt = add_sat(au_cnt, 24'd1);
                    ph     = PH_HEADER;
                end else begin
                    // Hold the slice start code aside until the next header decides
                    if (au_cnt != COUNT_MAX) begin
                        au_cnt = (au_cnt >= sc_len - 24'd1) ? au_cnt - (sc_len - 24'd1) : '0;
                    end
                    pend_cnt = sc_len;
                    ph       = PH_NEXT_HDR;
                end
            end
            PH_NEXT_HDR: begin
                pend_cnt = add_sat(pend_cnt, 24'd1);
                if (is_slice_hdr(b)) begin
                    win = {16'h0, ~b};
                    ph  = PH_NEXT_FIRST;
                end else begin
                    close_au(au_cnt, cur_idr);
                    au_cnt    = pend_cnt;
                    pend_cnt  = '0;
                    cur_slice = 1'b0;
                    cur_idr   = 1'b0;
                    win       = '0;
                    ph        = PH_BODY;
                end
            end
            PH_NEXT_FIRST: begin
                // Top bit set on the first slice byte starts a new picture
                hdr = ~win[7:0];
                grp = add_sat(pend_cnt, 24'd1);
                if (b[7]) begin
                    close_au(au_cnt, cur_idr);
                    au_cnt = grp;
                end else begin
                    au_cnt = add_sat(au_cnt, grp);
                end
                pend_cnt  = '0;
                cur_slice = 1'b1;
                cur_idr   = (hdr[4:0] == NAL_TYPE_IDR);
                win       = {16'h0, ~b};
                ph        = PH_BODY;
            end
            default: begin
                clear_parser();
            end
        endcase

        // Flush open slices at the end of the stream
        if (it.stream_end) begin
            if (ph == PH_NEXT_HDR) begin
                close_au(au_cnt, cur_idr);
            end else if (ph == PH_NEXT_FIRST) begin
                hdr = ~win[7:0];
                close_au(au_cnt, cur_idr);
                close_au(pend_cnt, hdr[4:0] == NAL_TYPE_IDR);
            end else if (ph == PH_BODY && cur_slice) begin
                close_au(au_cnt, cur_idr);
            end
            clear_parser();
        end

        if (step_aus.size() > 0) begin
            tail = step_aus.pop_back();
            tail.last_of_run = 1'b1;
            step_aus.push_back(tail);
        end
        foreach (step_aus[k]) begin
            pending_aus.push_back(step_aus[k]);
        end
    endtask

    // Drive the byte stream
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap   <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                parse_byte(in_data);
                bytes_taken++;
            end
            if (!in_valid || o_in_ready) begin
                if (tx_gap > 0) begin
                    tx_gap   <= tx_gap - 1;
                    in_valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    in_data  <= byte_q.pop_front();
                    in_valid <= 1'b1;
                    tx_gap   <= draw_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Take descriptors and check them against the scoreboard
    always @(posedge clk) begin : rx_side
        int        gap;
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pending_aus.size() == 0) begin
                    if (err_cnt < MAX_REPORTS) begin
                        $display("unexpected descriptor: bytes %0d idr %0b ts %0d clip %0b last %0b",
                                 o_out_data.frame_bytes, o_out_data.is_idr,
                                 o_out_data.timestamp, o_out_data.size_clipped,
                                 o_out_data.last_of_run);
                    end
                    err_cnt++;
                end else begin
                    want = pending_aus.pop_front();
                    if (o_out_data.frame_bytes !== want.frame_bytes ||
                        o_out_data.is_idr !== want.is_idr ||
                        o_out_data.timestamp !== want.timestamp ||
                        o_out_data.size_clipped !== want.size_clipped ||
                        o_out_data.last_of_run !== want.last_of_run) begin
                        if (err_cnt < MAX_REPORTS) begin
                            $display("descriptor mismatch: exp bytes %0d idr %0b ts %0d clip %0b last %0b",
                                     want.frame_bytes, want.is_idr, want.timestamp,
                                     want.size_clipped, want.last_of_run);
                            $display("                     got bytes %0d idr %0b ts %0d clip %0b last %0b",
                                     o_out_data.frame_bytes, o_out_data.is_idr,
                                     o_out_data.timestamp, o_out_data.size_clipped,
                                     o_out_data.last_of_run);
                        end
                        err_cnt++;
                    end
                end
            end

            // Long hold-off first, then the per-transaction gap
            if (rx_hold_req && !rx_hold_done) begin
                rx_hold_left <= RX_HOLD_CYCLES;
                rx_hold_done <= 1'b1;
                out_ready    <= 1'b0;
            end else if (rx_hold_left > 0) begin
                rx_hold_left <= rx_hold_left - 1;
                out_ready    <= 1'b0;
            end else if (o_out_valid && out_ready) begin
                gap = draw_gap();
                rx_wait   <= gap;
                out_ready <= (gap == 0);
            end else if (rx_wait > 0) begin
                rx_wait   <= rx_wait - 1;
                out_ready <= (rx_wait == 1);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Queue the buffered stream, flagging its last byte
    task automatic flush_stream();
        t_in_item it;
        foreach (stream_buf[k]) begin
            it.data_byte  = stream_buf[k];
            it.stream_end = (k == stream_buf.size() - 1);
            byte_q.push_back(it);
            bytes_queued++;
        end
        stream_buf.delete();
    endtask

    // Build a stream of well-formed NAL units, sometimes cut short at the end
    task automatic gen_nal_stream();
        int         n_nal;
        int         plen;
        int         cut;
        logic [4:0] typ;
        stream_buf.delete();
        repeat ($urandom_range(0, 2)) stream_buf.push_back(8'($urandom_range(0, 255)));
        n_nal = $urandom_range(1, 8);
        cut   = $urandom_range(0, 9);
        for (int i = 0; i < n_nal; i++) begin
            if ($urandom_range(0, 1) == 1) begin
                stream_buf.push_back(8'h00);
            end
            stream_buf.push_back(8'h00);
            stream_buf.push_back(8'h00);
            stream_buf.push_back(START_CODE_LAST);
            if (i == n_nal - 1 && cut == 0) begin
                break;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: typ = NAL_NON_IDR;
                3, 4:    typ = NAL_TYPE_IDR;
                5:       typ = 5'($urandom_range(NAL_NON_IDR + 1, NAL_PART_C));
                6:       typ = NAL_SPS;
                7:       typ = NAL_PPS;
                8:       typ = NAL_SEI;
                default: typ = 5'($urandom_range(NAL_UNSPEC, NAL_TYPE_TOP));
            endcase
            stream_buf.push_back({3'($urandom_range(0, 7)), typ});
            if (i == n_nal - 1 && cut == 1) begin
                break;
            end
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            repeat (plen) begin
                stream_buf.push_back(($urandom_range(0, 7) == 0) ? 8'h00
                                                                  : 8'($urandom_range(0, 255)));
            end
        end
        flush_stream();
    endtask

    // Short burst heavy in zeros and ones
    task automatic gen_noise();
        stream_buf.delete();
        repeat ($urandom_range(1, 40)) begin
            case ($urandom_range(0, 3))
                0, 1:    stream_buf.push_back(8'h00);
                2:       stream_buf.push_back(START_CODE_LAST);
                default: stream_buf.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        flush_stream();
    endtask

    // Wait until every queued byte is taken and every descriptor has come
    task automatic drain();
        do begin
            @(posedge clk);
        end while (bytes_taken != bytes_queued || pending_aus.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_FRAME_PERIOD) begin
            period = data[15:0];
        end
    endtask

    task automatic apb_check_period();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_FRAME_PERIOD;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[15:0] !== period) begin
            if (err_cnt < MAX_REPORTS) begin
                $display("frame_period read mismatch: exp %0d got %0d", period, prdata[15:0]);
            end
            err_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [15:0] phase_period;
        int          target;
        period = FRAME_PERIOD_RST;
        ts_now = '0;
        clear_parser();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Leading junk, 4- and 3-byte start codes, picture split on the top bit,
        // type zero after a slice, trailing non-slice dropped
        stream_buf = '{8'hAA, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h65,
                       8'h88, 8'h00, 8'h00, 8'h01, 8'h41, 8'h9A, 8'h00, 8'h00, 8'h01, 8'h00,
                       8'hFF};
        flush_stream();
        // Empty IDR slice, then a slice header cut off by the end: two descriptors
        stream_buf = '{8'h00, 8'h00, 8'h01, 8'h05, 8'h00, 8'h00, 8'h01, 8'h45};
        flush_stream();
        // Slice start code completing on the last byte
        stream_buf = '{8'h00, 8'h00, 8'h01, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h01};
        flush_stream();
        // Start code with no header at the end
        stream_buf = '{8'h00, 8'h00, 8'h01};
        flush_stream();
        drain();
        apb_check_period();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       phase_period = PERIOD_MIN;
                1:       phase_period = PERIOD_MAX;
                3:       phase_period = PERIOD_ONE;
                default: phase_period = 16'($urandom_range(0, 65535));
            endcase
            if (p == 2) begin
                apb_write(ADDR_UNMAPPED, $urandom());
            end
            apb_write(ADDR_FRAME_PERIOD, {16'h0, phase_period});
            apb_check_period();

            // One phase runs back to back and has the long receiver stall
            idle_on = (p != 3);
            target  = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target) begin
                if ($urandom_range(0, 6) == 0) begin
                    gen_noise();
                end else begin
                    gen_nal_stream();
                end
            end
            if (p == 3) begin
                @(posedge clk);
                rx_hold_req <= 1'b1;
            end
            drain();
        end

        err_cnt += pending_aus.size();
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
